### rtl/core/mouse_button_chatter_filter_core_macros.svh
// assertion macros for the mouse button chatter filter core
// no dependencies; assertions compile out when SYNTHESIS is defined
`ifndef MOUSE_BUTTON_CHATTER_FILTER_CORE_MACROS_SVH
`define MOUSE_BUTTON_CHATTER_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MBCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mbcf assertion failed");
// next-cycle implication
`define MBCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mbcf assertion failed");
`else
`define MBCF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MBCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/mbcf_pkg.sv
// shared types and constants for the mouse button chatter filter core
// no dependencies
`timescale 1ns / 1ps

package mbcf_pkg;

	localparam int DEF_DROP_COUNT_BITS = 8;
	localparam int DEF_TIME_BITS       = 32;
	localparam int APB_ADDR_BITS       = 5;
	localparam int APB_DATA_BITS       = 32;

	// request codes
	localparam logic [2:0] REQ_LEFT_PRESS    = 3'd0;
	localparam logic [2:0] REQ_RIGHT_PRESS   = 3'd1;
	localparam logic [2:0] REQ_LEFT_RELEASE  = 3'd2;
	localparam logic [2:0] REQ_RIGHT_RELEASE = 3'd3;
	localparam logic [2:0] REQ_TICK          = 3'd4;
	localparam logic [2:0] REQ_SET_SELECTION = 3'd5;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_ENABLE           = 3'd0;
	localparam logic [2:0] REG_LOG_ENABLE       = 3'd1;
	localparam logic [2:0] REG_DEBOUNCE_MS      = 3'd2;
	localparam logic [2:0] REG_HOLD_AUTO_ENABLE = 3'd3;
	localparam logic [2:0] REG_HOLD_DELAY_MS    = 3'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] now_ms;
		logic        selection_value;
	} evt_item_t;

	typedef struct packed {
		logic        forward;
		logic        inject_left_release;
		logic        log_valid;
		logic [31:0] log_interval_ms;
		logic        log_blocked;
		logic        log_right;
		logic        selection_active;
		logic        lock_held;
	} res_item_t;

	typedef struct packed {
		logic        enable;
		logic        log_enable;
		logic [15:0] debounce_ms;
		logic        hold_auto_enable;
		logic [15:0] hold_delay_ms;
	} cfg_t;

endpackage

### rtl/core/mbcf_apb_regs.sv
// apb configuration registers of the chatter filter
// depends on mbcf_pkg
`timescale 1ns / 1ps

module mbcf_apb_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [mbcf_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [mbcf_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [mbcf_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                  pready,
	output mbcf_pkg::cfg_t                        cfg
);

	mbcf_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable           <= 1'b0;
			cfg_q.log_enable       <= 1'b0;
			cfg_q.debounce_ms      <= 16'd1;
			cfg_q.hold_auto_enable <= 1'b0;
			cfg_q.hold_delay_ms    <= 16'd1;
		end else if (wr_en) begin
			case (reg_idx)
				mbcf_pkg::REG_ENABLE:           cfg_q.enable           <= pwdata[0];
				mbcf_pkg::REG_LOG_ENABLE:       cfg_q.log_enable       <= pwdata[0];
				mbcf_pkg::REG_DEBOUNCE_MS:      cfg_q.debounce_ms      <= pwdata[15:0];
				mbcf_pkg::REG_HOLD_AUTO_ENABLE: cfg_q.hold_auto_enable <= pwdata[0];
				mbcf_pkg::REG_HOLD_DELAY_MS:    cfg_q.hold_delay_ms    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mbcf_pkg::REG_ENABLE:           prdata = 32'(cfg_q.enable);
			mbcf_pkg::REG_LOG_ENABLE:       prdata = 32'(cfg_q.log_enable);
			mbcf_pkg::REG_DEBOUNCE_MS:      prdata = 32'(cfg_q.debounce_ms);
			mbcf_pkg::REG_HOLD_AUTO_ENABLE: prdata = 32'(cfg_q.hold_auto_enable);
			mbcf_pkg::REG_HOLD_DELAY_MS:    prdata = 32'(cfg_q.hold_delay_ms);
			default:                        prdata = '0;
		endcase
	end

endmodule

### rtl/core/mbcf_filter.sv
// filter state and per-beat decision logic of the chatter filter
// depends on mbcf_pkg
`timescale 1ns / 1ps

module mbcf_filter #(
	parameter int DROP_COUNT_BITS = mbcf_pkg::DEF_DROP_COUNT_BITS,
	parameter int TIME_BITS       = mbcf_pkg::DEF_TIME_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbcf_pkg::cfg_t      cfg,
	input  mbcf_pkg::evt_item_t item,
	input  logic                advance,
	output mbcf_pkg::res_item_t res
);

	localparam logic [DROP_COUNT_BITS-1:0] DROP_MAX = {DROP_COUNT_BITS{1'b1}};

	logic [TIME_BITS-1:0]       last_press_q, last_press_d;
	logic [TIME_BITS-1:0]       hold_start_q, hold_start_d;
	logic [DROP_COUNT_BITS-1:0] left_drops_q, left_drops_d;
	logic [DROP_COUNT_BITS-1:0] right_drops_q, right_drops_d;
	logic                       sel_q, sel_d;
	logic                       lock_q, lock_d;
	logic                       armed_q, armed_d;

	logic [TIME_BITS-1:0]       now_t;
	logic [TIME_BITS-1:0]       hold_elapsed;
	logic [TIME_BITS-1:0]       interval;
	logic                       hold_fire;
	logic                       is_right;
	logic                       chatter;
	logic [DROP_COUNT_BITS-1:0] cnt;

	assign now_t        = item.now_ms[TIME_BITS-1:0];
	assign hold_elapsed = now_t - hold_start_q;
	assign interval     = now_t - last_press_q;
	assign hold_fire    = armed_q && (hold_elapsed >= TIME_BITS'(cfg.hold_delay_ms));
	assign chatter      = interval <= TIME_BITS'(cfg.debounce_ms);
	assign is_right     = (item.req_type == mbcf_pkg::REQ_RIGHT_PRESS) ||
	                      (item.req_type == mbcf_pkg::REQ_RIGHT_RELEASE);
	assign cnt          = is_right ? right_drops_q : left_drops_q;

	always_comb begin
		last_press_d  = last_press_q;
		hold_start_d  = hold_start_q;
		left_drops_d  = left_drops_q;
		right_drops_d = right_drops_q;
		sel_d         = sel_q;
		lock_d        = lock_q;
		armed_d       = armed_q;
		res           = '0;
		res.forward   = 1'b1;

		// hold timer is checked first on every beat
		if (hold_fire) begin
			sel_d   = 1'b1;
			lock_d  = 1'b1;
			armed_d = 1'b0;
		end

		case (item.req_type)
			mbcf_pkg::REQ_LEFT_PRESS, mbcf_pkg::REQ_RIGHT_PRESS: begin
				if (cfg.enable) begin
					last_press_d = now_t;
					if (cfg.log_enable) begin
						res.log_valid       = 1'b1;
						res.log_interval_ms = 32'(interval);
						res.log_right       = is_right;
					end
					if (chatter) begin
						if (cnt != DROP_MAX) begin
							if (is_right) right_drops_d = cnt + 1'b1;
							else          left_drops_d  = cnt + 1'b1;
						end
						res.log_blocked = cfg.log_enable;
						res.forward     = 1'b0;
					end else if (!is_right) begin
						if (lock_d) begin
							// second press ends the drag lock
							lock_d                  = 1'b0;
							sel_d                   = 1'b0;
							res.inject_left_release = 1'b1;
							res.forward             = 1'b0;
						end else if (sel_d) begin
							lock_d = 1'b1;
						end else if (cfg.hold_auto_enable) begin
							armed_d      = 1'b1;
							hold_start_d = now_t;
						end
					end
				end
			end
			mbcf_pkg::REQ_LEFT_RELEASE, mbcf_pkg::REQ_RIGHT_RELEASE: begin
				if (cfg.enable) begin
					if (!is_right && (lock_d || sel_d)) begin
						if (cnt != '0) left_drops_d = cnt - 1'b1;
						res.forward = 1'b0;
					end else if (cnt != '0) begin
						if (is_right) right_drops_d = cnt - 1'b1;
						else          left_drops_d  = cnt - 1'b1;
						res.forward = 1'b0;
					end else if (cfg.hold_auto_enable) begin
						armed_d = 1'b0;
					end
				end
			end
			mbcf_pkg::REQ_SET_SELECTION: begin
				sel_d       = item.selection_value;
				res.forward = 1'b0;
			end
			default: ;
		endcase

		res.selection_active = sel_d;
		res.lock_held        = lock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_press_q  <= '0;
			hold_start_q  <= '0;
			left_drops_q  <= '0;
			right_drops_q <= '0;
			sel_q         <= 1'b0;
			lock_q        <= 1'b0;
			armed_q       <= 1'b0;
		end else if (advance) begin
			last_press_q  <= last_press_d;
			hold_start_q  <= hold_start_d;
			left_drops_q  <= left_drops_d;
			right_drops_q <= right_drops_d;
			sel_q         <= sel_d;
			lock_q        <= lock_d;
			armed_q       <= armed_d;
		end
	end

endmodule

### rtl/core/mouse_button_chatter_filter_core.sv
// mouse button chatter filter core: input register, filter step, result register
// each accepted beat goes through the input register, then the result register
// throughput: one event beat per cycle unless the result channel stalls
// the registers decouple channels: an empty input stage takes a beat while a result waits
// reset: arst_n clears all filter state, both valid flags, and presets the config registers
// depends on mbcf_pkg, mbcf_apb_regs, mbcf_filter and the assertion macro header
`timescale 1ns / 1ps
`include "mouse_button_chatter_filter_core_macros.svh"

module mouse_button_chatter_filter_core #(
	parameter int DROP_COUNT_BITS = mbcf_pkg::DEF_DROP_COUNT_BITS,
	parameter int TIME_BITS       = mbcf_pkg::DEF_TIME_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// event channel
	input  logic                               evt_valid,
	output logic                               evt_ready,
	input  mbcf_pkg::evt_item_t                evt,
	// result channel
	output logic                               res_valid,
	input  logic                               res_ready,
	output mbcf_pkg::res_item_t                res,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mbcf_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [mbcf_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [mbcf_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready
);

	mbcf_pkg::cfg_t      cfg;
	mbcf_pkg::evt_item_t item_s1;
	mbcf_pkg::res_item_t res_d;
	mbcf_pkg::res_item_t res_q;
	logic                valid_s1;
	logic                res_valid_q;
	logic                advance;
	logic                evt_take;

	// configuration registers
	mbcf_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the beat in the input register moves on when the result register is free
	// or is being emptied in this cycle; state and result update together
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || advance;
	assign evt_take  = evt_valid && evt_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			item_s1 <= evt;
		end
	end

	// filter decision and state update for the beat in the input register
	mbcf_filter #(
		.DROP_COUNT_BITS (DROP_COUNT_BITS),
		.TIME_BITS       (TIME_BITS)
	) u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.res     (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// an accepted event always lands in the input register
	`MBCF_ASSERT_NEXT(a_take_lands, clk, arst_n, evt_take, valid_s1)
	// an injected release ends both the lock and selection and swallows the press
	`MBCF_ASSERT_NOW(a_inject_clears, clk, arst_n, res_valid && res.inject_left_release,
		!res.forward && !res.lock_held && !res.selection_active)
	// a blocked press is always a logged, swallowed press
	`MBCF_ASSERT_NOW(a_blocked_logged, clk, arst_n, res_valid && res.log_blocked,
		res.log_valid && !res.forward)
	// log fields stay clear when nothing is logged
	`MBCF_ASSERT_NOW(a_log_quiet, clk, arst_n, res_valid && !res.log_valid,
		res.log_interval_ms == 32'd0 && !res.log_right && !res.log_blocked)

endmodule

### tb/mbcf_filter_monitor.sv
`timescale 1ns / 1ps
// monitor for the mouse button chatter filter core: predicts every result beat from its own
// copy of the filter state and configuration, then compares it field by field
// depends on mbcf_pkg
module mbcf_filter_monitor
	import mbcf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      evt_valid,
	input  logic                      evt_ready,
	input  evt_item_t                 evt,
	input  logic                      res_valid,
	input  logic                      res_ready,
	input  res_item_t                 res,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [APB_ADDR_BITS-1:0]  paddr,
	input  logic [APB_DATA_BITS-1:0]  pwdata,
	input  logic [APB_DATA_BITS-1:0]  prdata,
	output int                        mismatches,
	output int                        outstanding,
	output int                        results_seen
);

	localparam int TW          = DEF_TIME_BITS;
	localparam int DW          = DEF_DROP_COUNT_BITS;
	localparam int MAX_REPORTS = 10;

	cfg_t          cfg;
	logic [TW-1:0] last_press;
	logic [TW-1:0] hold_start;
	logic [DW-1:0] left_drops;
	logic [DW-1:0] right_drops;
	logic          sel_mode;
	logic          lock_on;
	logic          hold_on;
	res_item_t     pending_decisions[$];
	int            err_count;
	int            beats_out;

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		end
	endtask

	function automatic logic [31:0] reg_readback(input logic [2:0] idx);
		case (idx)
			REG_ENABLE:           return 32'(cfg.enable);
			REG_LOG_ENABLE:       return 32'(cfg.log_enable);
			REG_DEBOUNCE_MS:      return 32'(cfg.debounce_ms);
			REG_HOLD_AUTO_ENABLE: return 32'(cfg.hold_auto_enable);
			REG_HOLD_DELAY_MS:    return 32'(cfg.hold_delay_ms);
			default:              return '0;
		endcase
	endfunction

	// one filter step: updates the shadow state and returns the decision
	function automatic res_item_t filter_step(input evt_item_t e);
		res_item_t     r;
		logic [TW-1:0] now;
		logic [TW-1:0] gap;
		logic          is_right;
		r = '0;
		r.forward = 1'b1;
		now = e.now_ms[TW-1:0];
		// single hold timer, looked at before anything else
		if (hold_on && (now - hold_start) >= cfg.hold_delay_ms) begin
			sel_mode = 1'b1;
			lock_on  = 1'b1;
			hold_on  = 1'b0;
		end
		case (e.req_type)
			REQ_LEFT_PRESS, REQ_RIGHT_PRESS: begin
				if (cfg.enable) begin
					is_right   = (e.req_type == REQ_RIGHT_PRESS);
					gap        = now - last_press;
					last_press = now;
					if (cfg.log_enable) begin
						r.log_valid       = 1'b1;
						r.log_interval_ms = 32'(gap);
						r.log_right       = is_right;
					end
					if (gap <= cfg.debounce_ms) begin
						if (is_right) begin
							if (right_drops != '1)
								right_drops = right_drops + 1'b1;
						end else if (left_drops != '1) begin
							left_drops = left_drops + 1'b1;
						end
						r.log_blocked = r.log_valid;
						r.forward     = 1'b0;
					end else if (!is_right) begin
						if (lock_on) begin
							lock_on  = 1'b0;
							sel_mode = 1'b0;
							r.inject_left_release = 1'b1;
							r.forward = 1'b0;
						end else if (sel_mode) begin
							lock_on = 1'b1;
						end else if (cfg.hold_auto_enable) begin
							hold_on    = 1'b1;
							hold_start = now;
						end
					end
				end
			end
			REQ_LEFT_RELEASE: begin
				if (cfg.enable) begin
					if (lock_on || sel_mode) begin
						if (left_drops != '0)
							left_drops = left_drops - 1'b1;
						r.forward = 1'b0;
					end else if (left_drops != '0) begin
						left_drops = left_drops - 1'b1;
						r.forward = 1'b0;
					end else if (cfg.hold_auto_enable) begin
						hold_on = 1'b0;
					end
				end
			end
			REQ_RIGHT_RELEASE: begin
				if (cfg.enable) begin
					if (right_drops != '0) begin
						right_drops = right_drops - 1'b1;
						r.forward = 1'b0;
					end else if (cfg.hold_auto_enable) begin
						hold_on = 1'b0;
					end
				end
			end
			REQ_SET_SELECTION: begin
				sel_mode  = e.selection_value;
				r.forward = 1'b0;
			end
			default: ;
		endcase
		r.selection_active = sel_mode;
		r.lock_held        = lock_on;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_item_t want;
		if (!arst_n) begin
			cfg         = cfg_t'{1'b0, 1'b0, 16'd1, 1'b0, 16'd1};
			last_press  = '0;
			hold_start  = '0;
			left_drops  = '0;
			right_drops = '0;
			sel_mode    = 1'b0;
			lock_on     = 1'b0;
			hold_on     = 1'b0;
			pending_decisions.delete();
			err_count   = 0;
			beats_out   = 0;
		end else begin
			if (res_valid && res_ready) begin
				beats_out++;
				if (pending_decisions.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t result beat with nothing expected: 0x%0h", $time, res);
				end else begin
					want = pending_decisions.pop_front();
					check_field("forward", want.forward, res.forward);
					check_field("inject_left_release", want.inject_left_release,
						res.inject_left_release);
					check_field("log_valid", want.log_valid, res.log_valid);
					check_field("log_interval_ms", want.log_interval_ms, res.log_interval_ms);
					check_field("log_blocked", want.log_blocked, res.log_blocked);
					check_field("log_right", want.log_right, res.log_right);
					check_field("selection_active", want.selection_active, res.selection_active);
					check_field("lock_held", want.lock_held, res.lock_held);
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[4:2])
						REG_ENABLE:           cfg.enable           = pwdata[0];
						REG_LOG_ENABLE:       cfg.log_enable       = pwdata[0];
						REG_DEBOUNCE_MS:      cfg.debounce_ms      = pwdata[15:0];
						REG_HOLD_AUTO_ENABLE: cfg.hold_auto_enable = pwdata[0];
						REG_HOLD_DELAY_MS:    cfg.hold_delay_ms    = pwdata[15:0];
						default: ;
					endcase
				end else begin
					check_field("register readback", reg_readback(paddr[4:2]), prdata);
				end
			end
			if (evt_valid && evt_ready)
				pending_decisions.push_back(filter_step(evt));
		end
		mismatches   <= err_count;
		outstanding  <= pending_decisions.size();
		results_seen <= beats_out;
	end

endmodule

### tb/tb_mouse_button_chatter_filter_core.sv
`timescale 1ns / 1ps
// top of the mouse button chatter filter core testbench: clock, reset, register setup,
// event stimulus, result back-pressure, watchdog and verdict
// depends on mbcf_pkg, the core and mbcf_filter_monitor
module tb_mouse_button_chatter_filter_core;
	import mbcf_pkg::*;

	localparam int CLK_PERIOD      = 20;
	localparam int RESET_CYCLES    = 11;
	localparam int WATCHDOG_LIMIT  = 2000;  // idle cycles, far above the long hold-off
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 8;     // extra wait after the drain for any stray result beat
	localparam int PHASE_ITEMS     = 12;
	localparam int DROP_BURST      = 256;   // enough blocked presses to saturate the counter
	localparam int IDLE_PCT        = 37;

	logic                     clk;
	logic                     arst_n;
	logic                     evt_valid;
	logic                     evt_ready;
	evt_item_t                evt;
	logic                     res_valid;
	logic                     res_ready;
	res_item_t                res;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int          mismatches;
	int          outstanding;
	int          results_seen;
	int          sent_count;
	int          sender_idle;
	int          receiver_stall;
	bit          hold_off_request;
	bit          hold_off_done;
	int          idle_cycles;
	logic [31:0] clock_ms;      // running event time stamp
	bit          left_down;     // button state, used to build press/release pairs
	bit          right_down;

	mouse_button_chatter_filter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	mbcf_filter_monitor u_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt_valid    (evt_valid),
		.evt_ready    (evt_ready),
		.evt          (evt),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// watchdog: any beat on either channel or a completed register access counts as progress
	always @(posedge clk) begin
		if (!arst_n || (evt_valid && evt_ready) || (res_valid && res_ready)
				|| (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** mouse_button_chatter_filter_core: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stalls, plus one long hold-off that backs the block up
	initial begin
		hold_off_done = 1'b0;
		res_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_request && !hold_off_done) begin
				res_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				res_ready <= (receiver_stall == 0) || ($urandom_range(99, 0) >= receiver_stall);
				@(posedge clk);
			end
		end
	end

	function automatic evt_item_t mk_event(input logic [2:0] kind, input logic [31:0] t,
			input logic sel);
		evt_item_t e;
		e.req_type        = kind;
		e.now_ms          = t;
		e.selection_value = sel;
		return e;
	endfunction

	// one event beat; valid stays up after acceptance so back-to-back beats need no toggle
	task automatic send_event(input evt_item_t e);
		while (sender_idle != 0 && $urandom_range(99, 0) < sender_idle) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= e;
		do @(posedge clk); while (!evt_ready);
		sent_count++;
	endtask

	// setup then access phase; psel is left high so transfers can run back to back
	task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_ADDR_BITS'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// registers change only with nothing in flight
	task automatic program_config(input cfg_t c);
		int i;
		evt_valid <= 1'b0;
		while (results_seen != sent_count) @(posedge clk);
		apb_access(1'b1, REG_ENABLE, 32'(c.enable));
		apb_access(1'b1, REG_LOG_ENABLE, 32'(c.log_enable));
		apb_access(1'b1, REG_DEBOUNCE_MS, 32'(c.debounce_ms));
		apb_access(1'b1, REG_HOLD_AUTO_ENABLE, 32'(c.hold_auto_enable));
		apb_access(1'b1, REG_HOLD_DELAY_MS, 32'(c.hold_delay_ms));
		// read every register back, the monitor checks prdata
		for (i = int'(REG_ENABLE); i <= int'(REG_HOLD_DELAY_MS); i++)
			apb_access(1'b0, 3'(i), '0);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// mostly press/release pairs with time gaps spread around the debounce and hold
	// windows, plus ticks, selection writes, spare codes and stray releases
	task automatic run_random_phase(input cfg_t c, input int idle, input bit hold_off);
		int          k;
		int          pick;
		int          span;
		logic [2:0]  kind;
		logic [31:0] gap;
		program_config(c);
		sender_idle    = idle;
		receiver_stall = idle;
		if (hold_off)
			hold_off_request = 1'b1;
		span = (c.debounce_ms > c.hold_delay_ms) ? int'(c.debounce_ms) : int'(c.hold_delay_ms);
		span = span + 4;
		for (k = 0; k < PHASE_ITEMS; k++) begin
			if ($urandom_range(99, 0) < 5)
				gap = $urandom;   // wild jump, wraps the time base now and then
			else
				gap = $urandom_range(2 * span, 0);
			clock_ms = clock_ms + gap;
			pick = $urandom_range(99, 0);
			if (pick < 35) begin
				kind = left_down ? REQ_LEFT_RELEASE : REQ_LEFT_PRESS;
				left_down = !left_down;
			end else if (pick < 65) begin
				kind = right_down ? REQ_RIGHT_RELEASE : REQ_RIGHT_PRESS;
				right_down = !right_down;
			end else if (pick < 80) begin
				kind = REQ_TICK;
			end else if (pick < 88) begin
				kind = REQ_SET_SELECTION;
			end else if (pick < 95) begin
				kind = 3'($urandom_range(7, 0));   // any code, the spare ones included
			end else begin
				kind = $urandom_range(1, 0) ? REQ_LEFT_RELEASE : REQ_RIGHT_RELEASE;
			end
			send_event(mk_event(kind, clock_ms, 1'($urandom_range(1, 0))));
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		evt_valid        <= 1'b0;
		evt              <= '0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		sent_count       = 0;
		sender_idle      = IDLE_PCT;
		receiver_stall   = IDLE_PCT;
		hold_off_request = 1'b0;
		clock_ms         = '0;
		left_down        = 1'b0;
		right_down       = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk: chatter, dropped releases, drag lock, hold timer, wrap, spare codes
		program_config(cfg_t'{1'b1, 1'b1, 16'd5, 1'b1, 16'd10});
		send_event(mk_event(REQ_LEFT_PRESS, 32'd100, 1'b0));      // clean press, arms hold
		send_event(mk_event(REQ_TICK, 32'd105, 1'b1));            // hold not yet due
		send_event(mk_event(REQ_LEFT_PRESS, 32'd104, 1'b0));      // chatter, blocked
		send_event(mk_event(REQ_LEFT_RELEASE, 32'd106, 1'b1));    // matching release dropped
		send_event(mk_event(REQ_LEFT_RELEASE, 32'd107, 1'b0));    // passes, disarms hold
		send_event(mk_event(REQ_RIGHT_PRESS, 32'd200, 1'b0));
		send_event(mk_event(REQ_RIGHT_PRESS, 32'd205, 1'b1));     // exactly at the window edge
		send_event(mk_event(REQ_RIGHT_RELEASE, 32'd210, 1'b0));   // dropped
		send_event(mk_event(REQ_RIGHT_RELEASE, 32'd211, 1'b0));
		send_event(mk_event(REQ_LEFT_PRESS, 32'd300, 1'b0));      // arms hold
		send_event(mk_event(REQ_TICK, 32'd310, 1'b0));            // hold fires, lock set
		send_event(mk_event(REQ_LEFT_RELEASE, 32'd312, 1'b1));    // swallowed while locked
		send_event(mk_event(REQ_LEFT_PRESS, 32'd400, 1'b0));      // ends lock, injects release
		send_event(mk_event(REQ_SET_SELECTION, 32'd401, 1'b1));
		send_event(mk_event(REQ_LEFT_PRESS, 32'd500, 1'b0));      // selection on, lock arms
		send_event(mk_event(REQ_LEFT_RELEASE, 32'd501, 1'b0));
		send_event(mk_event(REQ_LEFT_PRESS, 32'd600, 1'b1));      // lock ends again
		send_event(mk_event(REQ_SET_SELECTION, 32'hFFFF_FFFF, 1'b0));
		send_event(mk_event(REQ_TICK + 3'd2, 32'd0, 1'b1));       // spare code, acts as tick
		send_event(mk_event(REQ_TICK + 3'd3, 32'hFFFF_FFFF, 1'b0));
		send_event(mk_event(REQ_RIGHT_PRESS, 32'hFFFF_FFFF, 1'b1));
		send_event(mk_event(REQ_LEFT_PRESS, 32'd2, 1'b0));        // interval wraps, blocked
		send_event(mk_event(REQ_LEFT_RELEASE, 32'd3, 1'b1));
		send_event(mk_event(REQ_RIGHT_RELEASE, 32'h8000_0000, 1'b1));

		// drop counter saturation: a burst of blocked right presses, then as many releases;
		// only the release beyond the counter's maximum passes
		program_config(cfg_t'{1'b1, 1'b1, 16'hFFFF, 1'b0, 16'd1});
		sender_idle    = 0;
		receiver_stall = 0;
		clock_ms       = 32'd1000;
		repeat (DROP_BURST) begin
			clock_ms = clock_ms + $urandom_range(50, 0);
			send_event(mk_event(REQ_RIGHT_PRESS, clock_ms, 1'($urandom_range(1, 0))));
		end
		repeat (DROP_BURST) begin
			clock_ms = clock_ms + $urandom_range(50, 0);
			send_event(mk_event(REQ_RIGHT_RELEASE, clock_ms, 1'($urandom_range(1, 0))));
		end

		// random phases over several settings, extremes included
		run_random_phase(cfg_t'{1'b1, 1'b1, 16'd20, 1'b1, 16'd50}, IDLE_PCT, 1'b0);
		// zero windows, no idling on either side
		run_random_phase(cfg_t'{1'b1, 1'b0, 16'd0, 1'b1, 16'd0}, 0, 1'b0);
		// widest windows, time base about to wrap
		clock_ms = 32'hFFFF_FF00;
		run_random_phase(cfg_t'{1'b1, 1'b1, 16'hFFFF, 1'b0, 16'hFFFF}, IDLE_PCT, 1'b0);
		// long result hold-off while events keep coming, input must stall
		run_random_phase(cfg_t'{1'b1, 1'b1, 16'd8, 1'b1, 16'd12}, 0, 1'b1);
		// filter off: presses and releases pass, selection and timer still act
		run_random_phase(cfg_t'{1'b0, 1'b1, 16'd100, 1'b1, 16'd30}, IDLE_PCT, 1'b0);
		run_random_phase(cfg_t'{1'b1, 1'($urandom_range(1, 0)), 16'($urandom_range(200, 0)),
			1'b1, 16'($urandom_range(200, 0))}, IDLE_PCT, 1'b0);
		run_random_phase(cfg_t'{1'b1, 1'b1, 16'd3, 1'b1, 16'd5}, IDLE_PCT, 1'b0);

		// drain, then wait DRAIN_CYCLES more for anything unexpected
		evt_valid <= 1'b0;
		while (results_seen != sent_count) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** mouse_button_chatter_filter_core: PASSED **");
		else
			$display("** mouse_button_chatter_filter_core: FAILED **");
		$finish;
	end

endmodule
